>>> hw/rtl/tec_pkg.sv
package tec_pkg;

	localparam int MaxTrees     = 16;
	localparam int NodesPerTree = 64;
	localparam int FeatSlots    = 32;
	localparam int MaxClasses   = 16;
	localparam int ValueWidth   = 16;

	localparam logic [2:0] ReqNode     = 3'd0;
	localparam logic [2:0] ReqLeafProb = 3'd1;
	localparam logic [2:0] ReqFeature  = 3'd2;
	localparam logic [2:0] ReqClassify = 3'd3;
	localparam logic [2:0] ReqProbs    = 3'd4;
	localparam logic [2:0] ReqClear    = 3'd5;

	localparam logic CfgTreeCount  = 1'b0;
	localparam logic CfgClassCount = 1'b1;

	// clamp a 5 bit register to 1 .. min(hi,16)
	function automatic logic [4:0] clamp_count(input logic [4:0] v, input int hi);
		logic [4:0] h;
		h = (hi > 16) ? 5'd16 : 5'(hi);
		if (v == 5'd0) return 5'd1;
		return (v > h) ? h : v;
	endfunction

endpackage

>>> hw/rtl/tec_ram.sv
module tec_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/tree_ensemble_classifier.sv
// Random forest inference. Writes of nodes, leaf probabilities and features and
// model clears are done when accepted and leave the block idle. A classify or
// probability request walks the voting trees one after the other; each tree
// passes a start state, a node memory read then a feature lookup and branch for
// each node visited, and a step to the next tree, and a leaf reached in
// probability mode accumulates class_count entries from the leaf probability
// memory. Results follow: a class scan and a single result in classify mode, or
// class_count results in probability mode, each from a sequential divider and
// then the output register. Output stalls hold the result path. Node and leaf
// memories hold undefined data until written; no clearing pass is made.
module tree_ensemble_classifier #(
	parameter int MAX_TREES      = tec_pkg::MaxTrees,
	parameter int NODES_PER_TREE = tec_pkg::NodesPerTree,
	parameter int FEAT_SLOTS     = tec_pkg::FeatSlots,
	parameter int MAX_CLASSES    = tec_pkg::MaxClasses
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [3:0]  tree_index,
	input  logic [5:0]  node_index,
	input  logic        is_leaf,
	input  logic [4:0]  feature_index,
	input  logic signed [15:0] threshold,
	input  logic signed [6:0]  left_child,
	input  logic signed [6:0]  right_child,
	input  logic [3:0]  leaf_class,
	input  logic [3:0]  class_index,
	input  logic [15:0] class_prob_in,
	input  logic signed [15:0] feature_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  predicted_class,
	output logic [15:0] class_prob,
	output logic        last
);
	localparam int TW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
	localparam int NW = $clog2(NODES_PER_TREE);
	localparam int FW = (FEAT_SLOTS > 1) ? $clog2(FEAT_SLOTS) : 1;
	localparam int NDEPTH = MAX_TREES * NODES_PER_TREE;
	localparam int LDEPTH = NDEPTH * MAX_CLASSES;
	localparam int NAW = $clog2(NDEPTH);
	localparam int LAW = $clog2(LDEPTH);
	localparam int NODE_W = 1 + 5 + 16 + 7 + 7 + 4;
	localparam int SW = 21;
	localparam int SC = $clog2(NODES_PER_TREE + 1);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_START = 10'b0000000010,
		ST_READ  = 10'b0000000100,
		ST_EVAL  = 10'b0000001000,
		ST_PROB  = 10'b0000010000,
		ST_NEXT  = 10'b0000100000,
		ST_SCAN  = 10'b0001000000,
		ST_DIV   = 10'b0010000000,
		ST_OUT   = 10'b0100000000,
		ST_PWAIT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [4:0] tree_count_q, class_count_q;
	logic [4:0] ntrees, ncls;
	assign ntrees = tec_pkg::clamp_count(tree_count_q, MAX_TREES);
	assign ncls   = tec_pkg::clamp_count(class_count_q, MAX_CLASSES);

	logic [6:0] node_cnt_q [MAX_TREES];
	logic signed [15:0] feat_q [FEAT_SLOTS];

	logic mode_prob_q;
	logic [4:0] tree_q;
	logic [NW-1:0] node_q;
	logic [SC-1:0] step_q;
	logic [4:0] cls_q, pcls_q;
	logic [SW-1:0] sum_q [16];
	logic [4:0] votes_q [16];
	logic [4:0] best_q, bestv_q;
	logic [SW-1:0] rem_q, quo_q;
	logic [4:0] div_cnt_q;
	logic [3:0] out_cls_q;
	logic [15:0] out_prob_q;
	logic out_last_q, out_valid_q;

	logic accept;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	// output register can take a new transaction this cycle
	logic out_free, out_load;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free &&
		((state_q == ST_SCAN && cls_q == ncls) || state_q == ST_OUT);

	// node memory
	logic n_we;
	logic [NAW-1:0] n_waddr, n_raddr;
	logic [NODE_W-1:0] n_wdata, n_rdata;
	assign n_we = accept && req_type == tec_pkg::ReqNode &&
		32'(tree_index) < MAX_TREES && 32'(node_index) < NODES_PER_TREE;
	assign n_waddr = NAW'(32'(tree_index) * NODES_PER_TREE + 32'(node_index));
	assign n_wdata = {is_leaf, feature_index, threshold, left_child, right_child, leaf_class};
	assign n_raddr = NAW'(32'(tree_q) * NODES_PER_TREE + 32'(node_q));

	tec_ram #(.Width(NODE_W), .Depth(NDEPTH)) u_nodes (
		.clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);

	logic nd_leaf;
	logic [4:0] nd_feat;
	logic signed [15:0] nd_thr;
	logic signed [6:0] nd_l, nd_r;
	logic [3:0] nd_cls;
	assign {nd_leaf, nd_feat, nd_thr, nd_l, nd_r, nd_cls} = n_rdata;

	// leaf probability memory
	logic l_we;
	logic [LAW-1:0] l_waddr, l_raddr;
	logic [15:0] l_rdata;
	assign l_we = accept && req_type == tec_pkg::ReqLeafProb &&
		32'(tree_index) < MAX_TREES && 32'(node_index) < NODES_PER_TREE &&
		32'(class_index) < MAX_CLASSES;
	assign l_waddr = LAW'((32'(tree_index) * NODES_PER_TREE + 32'(node_index))
		* MAX_CLASSES + 32'(class_index));
	assign l_raddr = LAW'((32'(tree_q) * NODES_PER_TREE + 32'(node_q))
		* MAX_CLASSES + 32'(cls_q));

	tec_ram #(.Width(16), .Depth(LDEPTH)) u_leaf (
		.clk, .we(l_we), .waddr(l_waddr), .wdata(class_prob_in),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	logic signed [15:0] fval;
	logic signed [6:0] child;
	always_comb begin
		fval = '0;
		if (32'(nd_feat) < FEAT_SLOTS) fval = feat_q[FW'(nd_feat)];
		child = (fval <= nd_thr) ? nd_l : nd_r;
	end

	logic [6:0] cur_cnt;
	assign cur_cnt = node_cnt_q[TW'(tree_q)];
	logic node_ok;
	assign node_ok = (32'(node_q) < 32'(cur_cnt)) && (32'(step_q) < NODES_PER_TREE);

	logic [SW:0] div_trial;
	assign div_trial = {rem_q[SW-1:0], quo_q[SW-1]} - (SW+1)'(ntrees);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tree_count_q <= 5'd1;
			class_count_q <= 5'd2;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TREES; i++) node_cnt_q[i] <= '0;
			for (int i = 0; i < FEAT_SLOTS; i++) feat_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == tec_pkg::CfgTreeCount) tree_count_q <= cfg_data;
				else class_count_q <= cfg_data;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							tec_pkg::ReqNode: begin
								if (n_we && node_cnt_q[TW'(tree_index)] < 7'(node_index) + 7'd1)
									node_cnt_q[TW'(tree_index)] <= 7'(node_index) + 7'd1;
							end
							tec_pkg::ReqFeature: begin
								if (32'(feature_index) < FEAT_SLOTS)
									feat_q[FW'(feature_index)] <= feature_value;
							end
							tec_pkg::ReqClear: begin
								for (int i = 0; i < MAX_TREES; i++) node_cnt_q[i] <= '0;
							end
							tec_pkg::ReqClassify, tec_pkg::ReqProbs: begin
								mode_prob_q <= (req_type == tec_pkg::ReqProbs);
								tree_q <= '0;
								for (int i = 0; i < 16; i++) begin
									sum_q[i] <= '0;
									votes_q[i] <= '0;
								end
								state_q <= ST_START;
							end
							default: ;
						endcase
					end
				end
				ST_START: begin
					node_q <= '0;
					step_q <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					// node memory address settles this cycle
					state_q <= node_ok ? ST_EVAL : ST_NEXT;
				end
				ST_EVAL: begin
					if (nd_leaf) begin
						if (mode_prob_q) begin
							cls_q <= '0;
							pcls_q <= '0;
							state_q <= ST_PROB;
						end else begin
							if (5'(nd_cls) < ncls) votes_q[nd_cls] <= votes_q[nd_cls] + 5'd1;
							state_q <= ST_NEXT;
						end
					end else if (child < 0) begin
						state_q <= ST_NEXT;
					end else begin
						node_q <= NW'(child);
						step_q <= step_q + 1'b1;
						if (32'(child) >= NODES_PER_TREE) state_q <= ST_NEXT;
						else state_q <= ST_READ;
					end
				end
				ST_PROB: begin
					// cls_q drives the read address, pcls_q trails it as a registered copy
					if (pcls_q != cls_q)
						sum_q[pcls_q[3:0]] <= sum_q[pcls_q[3:0]] + SW'(l_rdata);
					pcls_q <= cls_q;
					if (cls_q == ncls) state_q <= (pcls_q == cls_q) ? ST_NEXT : ST_PROB;
					else cls_q <= cls_q + 5'd1;
				end
				ST_NEXT: begin
					if (tree_q + 5'd1 == ntrees) begin
						cls_q <= '0;
						best_q <= '0;
						bestv_q <= '0;
						state_q <= mode_prob_q ? ST_DIV : ST_SCAN;
						quo_q <= sum_q[0];
						rem_q <= '0;
						div_cnt_q <= '0;
					end else begin
						tree_q <= tree_q + 5'd1;
						state_q <= ST_START;
					end
				end
				ST_SCAN: begin
					if (cls_q == ncls) begin
						if (out_free) begin
							out_cls_q <= best_q[3:0];
							out_prob_q <= '0;
							out_last_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						if (votes_q[cls_q[3:0]] > bestv_q) begin
							bestv_q <= votes_q[cls_q[3:0]];
							best_q <= cls_q;
						end
						cls_q <= cls_q + 5'd1;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (!div_trial[SW]) begin
						rem_q <= div_trial[SW-1:0];
						quo_q <= {quo_q[SW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[SW-2:0], quo_q[SW-1]};
						quo_q <= {quo_q[SW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(SW - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_cls_q <= cls_q[3:0];
						out_prob_q <= quo_q[15:0];
						out_last_q <= (cls_q + 5'd1 == ncls);
						if (cls_q + 5'd1 == ncls) state_q <= ST_IDLE;
						else begin
							cls_q <= cls_q + 5'd1;
							quo_q <= sum_q[4'(cls_q + 5'd1)];
							rem_q <= '0;
							div_cnt_q <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign predicted_class = out_cls_q;
	assign class_prob = out_prob_q;
	assign last = out_last_q;

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(class_prob) && $stable(last))
		else $error("result changed under stall");
	a_tree_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> tree_q < ntrees) else $error("tree past count");
	a_classify_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !mode_prob_q |-> class_prob == 16'd0 && last)
		else $error("classify result malformed");
endmodule
